[design/assert_macros.svh]
// Assertion helper macros shared by the RTL.
// No dependencies. Each check is clocked on i_clk and is off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define AST_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be true out of reset.
`define AST_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

[design/imup_pkg.sv]
// Shared constants, types and the type-byte decoder for the IMU frame parser.
// No dependencies.
`default_nettype none

package imup_pkg;

    localparam int unsigned DATA_LEN    = 8;
    localparam int unsigned STORE_DEPTH = DATA_LEN + 1;
    localparam int unsigned FRAME_LEN   = 11;
    localparam int unsigned CNT_W       = 4;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    localparam logic [1:0] GRP_ACCEL = 2'd0;
    localparam logic [1:0] GRP_GYRO  = 2'd1;
    localparam logic [1:0] GRP_ANGLE = 2'd2;

    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt CNT_IDLE = t_cnt'(0);
    localparam t_cnt CNT_HDR  = t_cnt'(1);
    localparam t_cnt CNT_LAST = t_cnt'(FRAME_LEN - 1);

    // Frame assembler status toward the decode/output stage.
    typedef struct packed {
        logic                           at_last;   // next byte closes the frame
        logic [7:0]                     type_byte;
        logic [DATA_LEN-1:0][7:0]       data;      // [0] is data byte 2
    } t_asm_stat;

    typedef struct packed {
        logic       known;
        logic [1:0] grp;
    } t_grp_dec;

    function automatic t_grp_dec decode_type(input logic [7:0] type_byte);
        t_grp_dec d;
        d.known = 1'b1;
        d.grp   = GRP_ACCEL;
        unique case (type_byte)
            TYPE_ACCEL: d.grp = GRP_ACCEL;
            TYPE_GYRO:  d.grp = GRP_GYRO;
            TYPE_ANGLE: d.grp = GRP_ANGLE;
            default:    d.known = 1'b0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[design/imu_uart_frame_parser.sv]
// Top level of the IMU serial frame parser: input handshake, decode, result register.
// Depends on imup_pkg, imup_frame_asm and assert_macros.svh.
`default_nettype none

// Takes one received serial byte per word and rebuilds 11-byte sensor frames:
// header 0x55, a type byte, eight data bytes and a trailing checksum that is
// accepted but not checked. Bytes other than 0x55 are dropped while no frame
// is open; a 0x55 inside a frame is plain data (no resync). On the eleventh
// byte the type picks the group (0x51 accel -> 0, 0x52 gyro -> 1, 0x53 angle
// -> 2) and one result word goes out in the next cycle with four signed
// 16-bit little-endian values; an unknown type closes the frame silently. A
// byte is accepted every clock, and the only input stall comes when the
// result register is still full and stalled at the moment a frame's last
// byte is due, since that byte needs the register.
module imu_uart_frame_parser
    import imup_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte input
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_rx_byte,
    // result output
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_group,
    output logic signed [15:0]      o_word_x,
    output logic signed [15:0]      o_word_y,
    output logic signed [15:0]      o_word_z,
    output logic signed [15:0]      o_word_temp
);

`include "assert_macros.svh"

    t_asm_stat          w_stat;
    t_grp_dec           w_dec;
    logic               w_accept;
    logic               w_emit;

    logic               r_out_valid;
    logic [1:0]         r_group;
    logic signed [15:0] r_word_x, r_word_y, r_word_z, r_word_temp;

    // hold the input only when the closing byte would find the result reg busy
    assign o_in_stall = w_stat.at_last && r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    imup_frame_asm u_asm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_stat    (w_stat)
    );

    assign w_dec  = decode_type(w_stat.type_byte);
    assign w_emit = w_accept && w_stat.at_last && w_dec.known;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // data bytes are little endian pairs: data[0..1] = x, ... data[6..7] = temp
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_group     <= w_dec.grp;
            r_word_x    <= {w_stat.data[1], w_stat.data[0]};
            r_word_y    <= {w_stat.data[3], w_stat.data[2]};
            r_word_z    <= {w_stat.data[5], w_stat.data[4]};
            r_word_temp <= {w_stat.data[7], w_stat.data[6]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_group     = r_group;
    assign o_word_x    = r_word_x;
    assign o_word_y    = r_word_y;
    assign o_word_z    = r_word_z;
    assign o_word_temp = r_word_temp;

    `AST_CLK(a_emit_shows, w_emit |=> o_out_valid,
        "decoded frame did not reach the output")
    `AST_CLK(a_rise_cause, $rose(o_out_valid) |-> $past(w_emit),
        "result appeared without a closing byte")
    `AST_CLK(a_stall_cause, o_in_stall |-> (o_out_valid && i_out_stall && w_stat.at_last),
        "input stalled without a busy result register")
    `AST_NEVER(a_group_code, o_out_valid && (o_group != GRP_ACCEL) &&
        (o_group != GRP_GYRO) && (o_group != GRP_ANGLE),
        "invalid group code on output")

endmodule

`default_nettype wire

[design/imup_frame_asm.sv]
// Frame assembler: header sync, byte counter and the nine-byte body shift line.
// Depends on imup_pkg and assert_macros.svh.
`default_nettype none

module imup_frame_asm
    import imup_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_rx_byte,
    output t_asm_stat       o_stat
);

`include "assert_macros.svh"

    t_cnt                          r_count, n_count;
    logic [STORE_DEPTH-1:0][7:0]   r_bytes;
    logic                          w_shift;

    // body bytes (type + eight data) arrive while count is 1..9
    assign w_shift = i_take && (r_count != CNT_IDLE) && (r_count < CNT_LAST);

    always_comb begin
        n_count = r_count;
        if (i_take) begin
            priority if (r_count == CNT_IDLE) begin
                if (i_rx_byte == HDR_BYTE) begin
                    n_count = CNT_HDR;
                end
            end else if (r_count < CNT_LAST) begin
                n_count = r_count + CNT_HDR;
            end else begin
                n_count = CNT_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_IDLE;
        end else begin
            r_count <= n_count;
        end
    end

    // oldest byte ends up at index 0 (type), newest enters at the top
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_bytes <= {i_rx_byte, r_bytes[STORE_DEPTH-1:1]};
        end
    end

    assign o_stat.at_last   = (r_count >= CNT_LAST);
    assign o_stat.type_byte = r_bytes[0];
    assign o_stat.data      = r_bytes[STORE_DEPTH-1:1];

    `AST_NEVER(a_cnt_range, r_count > CNT_LAST, "byte counter beyond frame end")
    `AST_CLK(a_close_frame, i_take && o_stat.at_last |=> r_count == CNT_IDLE,
        "frame did not close on last byte")

endmodule

`default_nettype wire
